// ----- rtl/jsv_pkg.sv -----
// Shared types, constants and character-class functions for the JSON stream validator.
// Depends on nothing; used by jsv_step and json_stream_validator.
package jsv_pkg;

	typedef enum logic [18:0] {
		M_VALUE     = 19'h00001,
		M_ARR_FIRST = 19'h00002,
		M_OBJ_FIRST = 19'h00004,
		M_KEY       = 19'h00008,
		M_COLON     = 19'h00010,
		M_AFTER     = 19'h00020,
		M_LIT       = 19'h00040,
		M_NUM_SIGN  = 19'h00080,
		M_NUM_ZERO  = 19'h00100,
		M_NUM_INT   = 19'h00200,
		M_NUM_DOT   = 19'h00400,
		M_NUM_FRAC  = 19'h00800,
		M_NUM_E     = 19'h01000,
		M_NUM_ESIGN = 19'h02000,
		M_NUM_EXP   = 19'h04000,
		M_STR       = 19'h08000,
		M_ESC       = 19'h10000,
		M_HEX       = 19'h20000,
		M_UTF8      = 19'h40000
	} mode_t;

	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;
	localparam logic [1:0] STR_KEY   = 2'd1;

	localparam logic [20:0] CP_MAX    = 21'h10FFFF;
	localparam logic [20:0] SURR_LO   = 21'h00D800;
	localparam logic [20:0] SURR_HI   = 21'h00DFFF;
	localparam logic [20:0] MIN_FOUR  = 21'h010000;
	localparam logic [20:0] MIN_THREE = 21'h000800;
	localparam logic [20:0] MIN_TWO   = 21'h000080;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  lit_kind;
		logic [2:0]  lit_idx;
		logic [2:0]  u_len;
		logic [1:0]  u_rem;
		logic [20:0] cp;
		logic [2:0]  hex_left;
		logic        err;
	} scan_t;

	typedef struct packed {
		logic push;
		logic push_bit;
		logic pop;
	} stack_op_t;

	localparam scan_t SCAN_RESET = '{mode: M_VALUE, lit_kind: 2'd0, lit_idx: 3'd0,
		u_len: 3'd0, u_rem: 2'd0, cp: 21'd0, hex_left: 3'd0, err: 1'b0};

	function automatic logic is_ws(input logic [7:0] c);
		return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09;
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dig(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] k);
		return (k == LIT_FALSE) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		case ({k, i})
			{LIT_TRUE, 3'd1}:  r = 8'h72;
			{LIT_TRUE, 3'd2}:  r = 8'h75;
			{LIT_TRUE, 3'd3}:  r = 8'h65;
			{LIT_FALSE, 3'd1}: r = 8'h61;
			{LIT_FALSE, 3'd2}: r = 8'h6C;
			{LIT_FALSE, 3'd3}: r = 8'h73;
			{LIT_FALSE, 3'd4}: r = 8'h65;
			{LIT_NULL, 3'd1}:  r = 8'h75;
			{LIT_NULL, 3'd2}:  r = 8'h6C;
			{LIT_NULL, 3'd3}:  r = 8'h6C;
			default:           r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/json_stream_validator.sv -----
// Streaming strict JSON syntax checker, one byte word per clock cycle unless text_stall is high.
// The verdict for the byte marked final is registered in the output register, or in the skid
// register while the output is held. The per-byte state update and top-of-stack register form
// the feedback loop; the container stack RAM is read one entry below the top in advance.
// Reset (arst_n low) returns the parser to "expect a value" with no containers open; the stack
// RAM itself is not cleared and needs no clearing pass.
module json_stream_validator import jsv_pkg::*; #(
	parameter int MAX_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       final_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       document_ok
);

	localparam int DW = $clog2(MAX_DEPTH + 2);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	// Parser state: mode and counters, the open depth, and the innermost container kind.
	scan_t         scan_q;
	logic [DW-1:0] depth_q;
	logic          tos_q;

	// The RAM holds every open container mark except the innermost one. Its read port always
	// points at the entry just below the top so that a closing bracket finds the new top ready.
	// A push writes exactly that entry, so for the following cycle the written mark is forwarded.
	logic          fwd_q;
	logic          fwd_data_q;
	logic          ram_rd_data;
	logic          below;

	scan_t         scan_n;
	logic [DW-1:0] depth_n;
	stack_op_t     op;

	logic          accept;
	logic          take;
	logic          verdict;
	logic [DW-1:0] rd_ptr;
	logic [DW-1:0] wr_ptr;

	// Two-entry result buffer: the output register plus a skid register.
	logic          out_valid_q;
	logic          out_ok_q;
	logic          skid_valid_q;
	logic          skid_ok_q;

	assign text_stall   = skid_valid_q;
	assign accept       = text_valid && !skid_valid_q;
	assign take         = out_valid_q && !result_stall;
	assign result_valid = out_valid_q;
	assign document_ok  = out_ok_q;
	assign below        = fwd_q ? fwd_data_q : ram_rd_data;

	jsv_step #(.MAX_DEPTH(MAX_DEPTH)) u_step (
		.cur       (scan_q),
		.depth     (depth_q),
		.tos       (tos_q),
		.c         (text_byte),
		.nxt       (scan_n),
		.depth_nxt (depth_n),
		.op        (op)
	);

	// A document is accepted when no error was seen, every container is closed, and the parser
	// stands after a complete value or at the end of a number that may legally stop there.
	assign verdict = !scan_n.err && depth_n == '0 &&
		(scan_n.mode == M_AFTER || scan_n.mode == M_NUM_ZERO || scan_n.mode == M_NUM_INT ||
		 scan_n.mode == M_NUM_FRAC || scan_n.mode == M_NUM_EXP);

	// The read pointer follows the depth the parser is about to hold; a final byte resets it.
	always_comb begin
		if (accept) rd_ptr = (final_byte ? DW'(0) : depth_n) - DW'(2);
		else rd_ptr = depth_q - DW'(2);
	end
	assign wr_ptr = depth_q - DW'(1);

	jsv_ram #(.WIDTH(1), .DEPTH(MAX_DEPTH)) u_stack (
		.clk     (clk),
		.wr_en   (accept && op.push && depth_q != '0),
		.wr_addr (wr_ptr[AW-1:0]),
		.wr_data (tos_q),
		.rd_addr (rd_ptr[AW-1:0]),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= SCAN_RESET;
			depth_q    <= '0;
			tos_q      <= 1'b0;
			fwd_q      <= 1'b0;
			fwd_data_q <= 1'b0;
		end else begin
			fwd_q <= 1'b0;
			if (accept) begin
				if (final_byte) begin
					scan_q  <= SCAN_RESET;
					depth_q <= '0;
					tos_q   <= 1'b0;
				end else begin
					scan_q  <= scan_n;
					depth_q <= depth_n;
					if (op.push) begin
						tos_q      <= op.push_bit;
						fwd_q      <= 1'b1;
						fwd_data_q <= tos_q;
					end else if (op.pop) begin
						tos_q <= below;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || (take && !skid_valid_q)) begin
				out_valid_q <= accept && final_byte;
			end else if (take) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else if (accept && final_byte) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || (take && !skid_valid_q)) begin
			out_ok_q <= verdict;
		end else if (take) begin
			out_ok_q <= skid_ok_q;
		end
		if (out_valid_q && !take && !skid_valid_q) begin
			skid_ok_q <= verdict;
		end
	end

endmodule

// ----- rtl/jsv_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module jsv_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/jsv_step.sv -----
// Next-state logic of the parser for one byte: grammar, literals, escapes and UTF-8 checks.
// Depends on jsv_pkg; instantiated by json_stream_validator.
module jsv_step import jsv_pkg::*; #(
	parameter int MAX_DEPTH = 256,
	localparam int DW = $clog2(MAX_DEPTH + 2)
) (
	input  scan_t           cur,
	input  logic [DW-1:0]   depth,
	input  logic            tos,
	input  logic [7:0]      c,
	output scan_t           nxt,
	output logic [DW-1:0]   depth_nxt,
	output stack_op_t       op
);

	localparam logic [DW-1:0] DEPTH_LIMIT = DW'(MAX_DEPTH);

	logic        start;
	logic        after;
	logic        pop_req;
	logic [20:0] cp_new;
	logic [1:0]  rem_new;

	always_comb begin
		nxt       = cur;
		depth_nxt = depth;
		op        = '0;
		start     = 1'b0;
		after     = 1'b0;
		pop_req   = 1'b0;
		cp_new    = {cur.cp[14:0], c[5:0]};
		rem_new   = cur.u_rem - 2'd1;
		if (!cur.err) begin
			case (cur.mode)
				M_VALUE: begin
					if (!is_ws(c)) start = 1'b1;
				end
				M_ARR_FIRST: begin
					if (!is_ws(c)) begin
						if (c == 8'h5D) pop_req = 1'b1;
						else start = 1'b1;
					end
				end
				M_OBJ_FIRST: begin
					if (!is_ws(c)) begin
						if (c == 8'h7D) pop_req = 1'b1;
						else if (c == 8'h22) begin
							nxt.lit_kind = STR_KEY;
							nxt.mode     = M_STR;
						end else nxt.err = 1'b1;
					end
				end
				M_KEY: begin
					if (!is_ws(c)) begin
						if (c == 8'h22) begin
							nxt.lit_kind = STR_KEY;
							nxt.mode     = M_STR;
						end else nxt.err = 1'b1;
					end
				end
				M_COLON: begin
					if (!is_ws(c)) begin
						if (c == 8'h3A) nxt.mode = M_VALUE;
						else nxt.err = 1'b1;
					end
				end
				M_AFTER: after = 1'b1;
				M_LIT: begin
					if (cur.lit_idx >= lit_len(cur.lit_kind) ||
					    c != lit_char(cur.lit_kind, cur.lit_idx)) begin
						nxt.err = 1'b1;
					end else begin
						nxt.lit_idx = cur.lit_idx + 3'd1;
						if (cur.lit_idx + 3'd1 == lit_len(cur.lit_kind)) nxt.mode = M_AFTER;
					end
				end
				M_NUM_SIGN: begin
					if (c == 8'h30) nxt.mode = M_NUM_ZERO;
					else if (is_dig(c)) nxt.mode = M_NUM_INT;
					else nxt.err = 1'b1;
				end
				M_NUM_ZERO, M_NUM_INT: begin
					if (cur.mode == M_NUM_INT && is_dig(c)) begin
						nxt.mode = M_NUM_INT;
					end else if (c == 8'h2E) nxt.mode = M_NUM_DOT;
					else if (c == 8'h65 || c == 8'h45) nxt.mode = M_NUM_E;
					else after = 1'b1;
				end
				M_NUM_DOT: begin
					if (is_dig(c)) nxt.mode = M_NUM_FRAC;
					else nxt.err = 1'b1;
				end
				M_NUM_FRAC: begin
					if (!is_dig(c)) begin
						if (c == 8'h65 || c == 8'h45) nxt.mode = M_NUM_E;
						else after = 1'b1;
					end
				end
				M_NUM_E: begin
					if (c == 8'h2B || c == 8'h2D) nxt.mode = M_NUM_ESIGN;
					else if (is_dig(c)) nxt.mode = M_NUM_EXP;
					else nxt.err = 1'b1;
				end
				M_NUM_ESIGN: begin
					if (is_dig(c)) nxt.mode = M_NUM_EXP;
					else nxt.err = 1'b1;
				end
				M_NUM_EXP: begin
					if (!is_dig(c)) after = 1'b1;
				end
				M_STR: begin
					if (c == 8'h22) nxt.mode = (cur.lit_kind == STR_KEY) ? M_COLON : M_AFTER;
					else if (c < 8'h20) nxt.err = 1'b1;
					else if (c == 8'h5C) nxt.mode = M_ESC;
					else if (c >= 8'h80) begin
						if ((c & 8'hE0) == 8'hC0) begin
							nxt.u_len = 3'd2;
							nxt.u_rem = 2'd1;
							nxt.cp    = {16'd0, c[4:0]};
							nxt.mode  = M_UTF8;
						end else if ((c & 8'hF0) == 8'hE0) begin
							nxt.u_len = 3'd3;
							nxt.u_rem = 2'd2;
							nxt.cp    = {17'd0, c[3:0]};
							nxt.mode  = M_UTF8;
						end else if ((c & 8'hF8) == 8'hF0) begin
							nxt.u_len = 3'd4;
							nxt.u_rem = 2'd3;
							nxt.cp    = {18'd0, c[2:0]};
							nxt.mode  = M_UTF8;
						end else nxt.err = 1'b1;
					end
				end
				M_ESC: begin
					if (c == 8'h75) begin
						nxt.hex_left = 3'd4;
						nxt.mode     = M_HEX;
					end else if (c == 8'h22 || c == 8'h5C || c == 8'h2F || c == 8'h62 ||
					             c == 8'h66 || c == 8'h6E || c == 8'h72 || c == 8'h74) begin
						nxt.mode = M_STR;
					end else nxt.err = 1'b1;
				end
				M_HEX: begin
					if (!is_hex(c) || cur.hex_left == 3'd0) nxt.err = 1'b1;
					else begin
						nxt.hex_left = cur.hex_left - 3'd1;
						if (cur.hex_left == 3'd1) nxt.mode = M_STR;
					end
				end
				M_UTF8: begin
					if ((c & 8'hC0) != 8'h80) nxt.err = 1'b1;
					else begin
						nxt.cp    = cp_new;
						nxt.u_rem = rem_new;
						if (rem_new == 2'd0) begin
							if ((cur.u_len == 3'd2 && cp_new < MIN_TWO) ||
							    (cur.u_len == 3'd3 && cp_new < MIN_THREE) ||
							    (cur.u_len == 3'd4 && cp_new < MIN_FOUR) ||
							    cp_new > CP_MAX ||
							    (cp_new >= SURR_LO && cp_new <= SURR_HI)) begin
								nxt.err = 1'b1;
							end else nxt.mode = M_STR;
						end
					end
				end
				default: nxt.err = 1'b1;
			endcase

			if (start) begin
				if (depth > DEPTH_LIMIT) nxt.err = 1'b1;
				else if (c == 8'h7B || c == 8'h5B) begin
					op.push     = 1'b1;
					op.push_bit = (c == 8'h5B);
					depth_nxt   = depth + DW'(1);
					nxt.mode    = (c == 8'h5B) ? M_ARR_FIRST : M_OBJ_FIRST;
				end else if (c == 8'h22) begin
					nxt.lit_kind = 2'd0;
					nxt.mode     = M_STR;
				end else if (c == 8'h74 || c == 8'h66 || c == 8'h6E) begin
					nxt.lit_kind = (c == 8'h74) ? LIT_TRUE : (c == 8'h66) ? LIT_FALSE : LIT_NULL;
					nxt.lit_idx  = 3'd1;
					nxt.mode     = M_LIT;
				end else if (c == 8'h2D) nxt.mode = M_NUM_SIGN;
				else if (c == 8'h30) nxt.mode = M_NUM_ZERO;
				else if (is_dig(c)) nxt.mode = M_NUM_INT;
				else nxt.err = 1'b1;
			end

			if (after) begin
				nxt.mode = M_AFTER;
				if (!is_ws(c)) begin
					if (depth == '0) nxt.err = 1'b1;
					else if (c == 8'h2C) nxt.mode = tos ? M_VALUE : M_KEY;
					else if ((c == 8'h7D && !tos) || (c == 8'h5D && tos)) pop_req = 1'b1;
					else nxt.err = 1'b1;
				end
			end

			if (pop_req) begin
				if (depth == '0) nxt.err = 1'b1;
				else begin
					op.pop    = 1'b1;
					depth_nxt = depth - DW'(1);
					nxt.mode  = M_AFTER;
				end
			end
		end
	end

endmodule
